[rtl/isu_pkg.sv]
package isu_pkg;

  localparam int EVENT_W   = 10;
  localparam int INTV_W    = 24;
  localparam int CFG_REGS  = 4;
  localparam int TABLE_MAX = 16;
  localparam int IDX_W     = 4;

  localparam logic [INTV_W-1:0] INTERVAL_MAX = 24'hFFFFFF;
  localparam logic [7:0]        WILDCARD     = 8'hFF;
  localparam logic [7:0]        NEVER        = 8'hEE;
  localparam int                NET_ENTRY    = 1;
  localparam int                SWELL_EVE_ENTRY = 6;

  localparam logic [1:0] FUNC_TICK = 2'd0;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_OFFLINE = 2'd1,
    MODE_ONLINE  = 2'd2,
    MODE_UPDATE  = 2'd3
  } mode_t;

  // One decoded item as seen by the entry banks.
  typedef struct packed {
    logic        tick;
    logic        go_offline;
    logic        go_online;
    logic        go_update;
    logic [31:0] now;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } sched_op_t;

  function automatic logic [7:0] clk_hour(input logic [IDX_W-1:0] idx);
    logic [7:0] h;
    unique case (idx)
      4'd0:    h = WILDCARD;
      4'd1:    h = 8'd0;
      4'd2:    h = WILDCARD;
      4'd3:    h = 8'd3;
      4'd4:    h = 8'd12;
      4'd5:    h = 8'd21;
      4'd6:    h = 8'd17;
      default: h = NEVER;
    endcase
    return h;
  endfunction

  function automatic logic [7:0] clk_minute(input logic [IDX_W-1:0] idx);
    logic [7:0] m;
    unique case (idx)
      4'd0:    m = WILDCARD;
      4'd1:    m = 8'd1;
      4'd2:    m = 8'd5;
      4'd3,
      4'd4,
      4'd5,
      4'd6:    m = 8'd0;
      default: m = NEVER;
    endcase
    return m;
  endfunction

  function automatic logic [EVENT_W-1:0] clk_event(input logic [IDX_W-1:0] idx);
    logic [EVENT_W-1:0] e;
    unique case (idx)
      4'd0:    e = 10'h008;
      4'd1:    e = 10'h100;
      4'd2:    e = 10'h001;
      4'd3:    e = 10'h002;
      4'd4,
      4'd5,
      4'd6:    e = 10'h004;
      4'd7:    e = 10'h010;
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic clk_force_online(input logic [IDX_W-1:0] idx);
    logic f;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd7: f = 1'b1;
      default:                            f = 1'b0;
    endcase
    return f;
  endfunction

  function automatic logic [EVENT_W-1:0] intv_event(input logic [IDX_W-1:0] idx);
    logic [EVENT_W-1:0] e;
    unique case (idx)
      4'd0:    e = 10'h020;
      4'd1:    e = 10'h040;
      4'd2:    e = 10'h080;
      4'd3:    e = 10'h200;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[rtl/isu_intv.sv]
module isu_intv
  import isu_pkg::*;
#(
  parameter int ENTRIES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  sched_op_t                        op,
  input  logic [CFG_REGS-1:0][INTV_W-1:0]  cfg_interval,
  output logic [EVENT_W-1:0]               events
);

  logic [ENTRIES-1:0] fire;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_ent
    logic              active;
    logic [31:0]       last;
    logic [INTV_W-1:0] ival;
    logic [32:0]       diff;

    if (i < CFG_REGS) begin : g_cfg
      assign ival = cfg_interval[i];
    end else begin : g_max
      assign ival = INTERVAL_MAX;
    end

    // Signed time since the last firing; a clock that moved back gives a negative value.
    assign diff    = {1'b0, op.now} - {1'b0, last};
    assign fire[i] = active && op.tick && ($signed(diff) > $signed({9'b0, ival}));

    always_ff @(posedge clk) begin
      if (rst) begin
        active <= 1'b0;
        last   <= '0;
      end else if (go) begin
        if (op.tick) begin
          if (fire[i]) last <= op.now;
        end else if (op.go_offline) begin
          active <= (i == NET_ENTRY);
        end else if (op.go_online) begin
          active <= (i != NET_ENTRY);
          if (i != NET_ENTRY) last <= op.now;
        end else if (op.go_update) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    events = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire[i]) events = events | intv_event(IDX_W'(i));
    end
  end

endmodule

[rtl/isu_clk.sv]
module isu_clk
  import isu_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  sched_op_t          op,
  output logic [EVENT_W-1:0] events
);

  logic [ENTRIES-1:0] fire;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_ent
    localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
    logic       active;
    logic       force_fire;
    logic [4:0] last_hour;
    logic [5:0] last_minute;
    logic       hour_ok;
    logic       minute_ok;
    logic       hit;

    assign hour_ok   = ({3'b0, op.hour} == clk_hour(IDX)) || (clk_hour(IDX) == WILDCARD);
    assign minute_ok = ({2'b0, op.minute} == clk_minute(IDX)) ||
                       (clk_minute(IDX) == WILDCARD);
    // Fire once per matching minute.
    assign hit     = hour_ok && minute_ok &&
                     (op.hour != last_hour || op.minute != last_minute);
    assign fire[i] = active && op.tick && (hit || force_fire);

    always_ff @(posedge clk) begin
      if (rst) begin
        active      <= 1'b0;
        force_fire  <= (i == SWELL_EVE_ENTRY);
        last_hour   <= '0;
        last_minute <= '0;
      end else if (go) begin
        if (op.tick) begin
          if (fire[i]) begin
            last_hour   <= op.hour;
            last_minute <= op.minute;
            force_fire  <= 1'b0;
          end
        end else if (op.go_offline) begin
          active <= 1'b0;
        end else if (op.go_online) begin
          active     <= 1'b1;
          force_fire <= clk_force_online(IDX);
        end else if (op.go_update) begin
          // Time and date entries stay as they are.
          if (i > 1) active <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    events = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire[i]) events = events | clk_event(IDX_W'(i));
    end
  end

endmodule

[rtl/interval_and_clock_event_scheduler_unit.sv]
// Channel   Direction  Signals                          Contents
// s_*       in         tvalid tready tdata[47:0] tuser  tick or mode command
// m_*       out        tvalid tready tdata[15:0]        event bits and mode
// apb       in/out     psel penable pwrite paddr[3:0]   four 24-bit interval registers
//
// An item is held in the input register and then moves to the output register;
// one item is accepted every cycle while the output is not stalled.
// The entry state is updated as an item moves to the output register.
// When the output is stalled the input register holds one more item.
// Reset is synchronous; no clearing pass is needed after it.
module interval_and_clock_event_scheduler_unit
  import isu_pkg::*;
#(
  parameter int INTERVAL_ENTRIES = 4,
  parameter int CLOCK_ENTRIES    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // epoch_seconds[31:0], hour[36:32], minute[42:37]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // event_bits[9:0], current_mode[11:10]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_REGS-1:0][INTV_W-1:0] cfg_interval;

  logic        in_valid;
  logic [1:0]  in_func;
  logic [31:0] in_now;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;

  logic               out_valid;
  logic [EVENT_W-1:0] out_events;
  mode_t              out_mode;

  mode_t              mode;
  mode_t              mode_next;
  logic               advance;
  logic               go;
  logic               is_cmd;
  sched_op_t          op;
  logic [EVENT_W-1:0] intv_events;
  logic [EVENT_W-1:0] clk_events;

  assign pready = 1'b1;
  assign prdata = {8'b0, cfg_interval[paddr[3:2]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_interval[0] <= 24'd86400;
      cfg_interval[1] <= 24'd30;
      cfg_interval[2] <= 24'd1800;
      cfg_interval[3] <= 24'd3600;
    end else if (psel && penable && pwrite && pready) begin
      cfg_interval[paddr[3:2]] <= pwdata[INTV_W-1:0];
    end
  end

  assign advance  = !out_valid || m_tready;
  assign go       = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func   <= s_tuser;
      in_now    <= s_tdata[31:0];
      in_hour   <= s_tdata[36:32];
      in_minute <= s_tdata[42:37];
    end
  end

  // A command for the mode already in force changes nothing.
  assign is_cmd = (in_func != FUNC_TICK) && (in_func != mode);

  always_comb begin
    op.tick       = (in_func == FUNC_TICK);
    op.go_offline = is_cmd && (in_func == MODE_OFFLINE);
    op.go_online  = is_cmd && (in_func == MODE_ONLINE);
    op.go_update  = is_cmd && (in_func == MODE_UPDATE);
    op.now        = in_now;
    op.hour       = in_hour;
    op.minute     = in_minute;
    mode_next     = is_cmd ? mode_t'(in_func) : mode;
  end

  isu_intv #(
    .ENTRIES(INTERVAL_ENTRIES)
  ) u_intv (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .op           (op),
    .cfg_interval (cfg_interval),
    .events       (intv_events)
  );

  isu_clk #(
    .ENTRIES(CLOCK_ENTRIES)
  ) u_clk (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .op     (op),
    .events (clk_events)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mode      <= MODE_INIT;
    end else begin
      if (advance) out_valid <= in_valid;
      if (go) mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_events <= intv_events | clk_events;
      out_mode   <= mode_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_mode, out_events};

`ifndef ASSERT_OFF
  a_cmd_no_events: assert property (@(posedge clk) disable iff (rst)
    go && !op.tick |=> out_events == '0)
    else $error("mode command produced event bits");

  a_mode_no_init: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_INIT |=> mode != MODE_INIT)
    else $error("mode returned to init");

  a_offline_net_only: assert property (@(posedge clk) disable iff (rst)
    go && op.tick && mode == MODE_OFFLINE |=> (out_events & ~10'h040) == '0)
    else $error("offline tick fired an entry other than network check");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_func) && $stable(in_now))
    else $error("pending item lost while output stalled");
`endif

endmodule
